// ===== hdl/gdsnm_pkg.sv =====
// gdsnm_pkg: opcodes, register indexes, sequencer states and constants
// for the influence grid block; depends on nothing
package gdsnm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_STAMP  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_TOWARD = 2'd3
  } opcode_t;

  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;

  localparam logic [8:0]  MAP_SIZE_RESET = 9'd256;
  localparam logic [16:0] BEST_NONE      = 17'h10000;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_STAMP_R2,
    ST_STAMP_COL,
    ST_STAMP_CELL,
    ST_Q_OWN_RD,
    ST_Q_OWN,
    ST_Q_NB_RD,
    ST_Q_NB_CHK,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/grid_disc_stamp_and_neighbour_min_top.sv =====
// influence grid top level: score memory, one shared squaring unit and its sequencer
// depends on gdsnm_pkg
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid in_ready opcode center_x .. target_y  | into block
//  out     | out_valid out_ready waypoint_x/y done_opcode   | out of block
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data         | into block
//
// after reset a clearing pass writes zero over all GRID_COLS*GRID_ROWS cells,
//   one cell a cycle; no item transfer is taken meanwhile, cfg writes are taken
// clear zeroes the width*height map cells in turn; stamp is paced by the single
//   memory write port and the shared squaring unit; query reads its own cell if in
//   the map, then checks the 3x3 cells around it, skipping those outside the map
// the block takes one item at a time; a finished result waits in the output
//   register while the next item is already taken and worked on
module grid_disc_stamp_and_neighbour_min_top #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [11:0] center_x,
  input  logic [11:0] center_y,
  input  logic [8:0]  radius,
  input  logic [15:0] score,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [11:0] target_x,
  input  logic [11:0] target_y,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  waypoint_x,
  output logic [7:0]  waypoint_y,
  output logic [1:0]  done_opcode,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import gdsnm_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);

  // configuration
  logic [8:0] map_width, map_height;
  logic [8:0] eff_w, eff_h;

  // sequencer
  state_t state, state_next;
  logic [AW-1:0] init_cnt;

  // latched item
  opcode_t    op_reg;
  logic [11:0] cen_x, cen_y, qp_x, qp_y, tg_x, tg_y;
  logic [8:0]  rad;
  logic [15:0] sc_val;

  // loop counters
  logic [8:0] x_cnt, y_cnt;
  logic [1:0] nx, ny;

  // datapath registers
  logic [17:0] r2;
  logic [26:0] tmp;
  logic [27:0] own_d;
  logic [16:0] best;
  logic [7:0]  bx, by;
  logic [15:0] rdata;

  // memory
  logic [15:0]   mem [DEPTH];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;

  // shared squaring unit
  logic signed [13:0] mul_in;
  logic signed [27:0] mul_prod;
  logic [26:0]        mul_out;

  // stamp box, upper ends exclusive
  logic signed [13:0] lo_x, lo_y;
  logic [12:0]        hi_x, hi_y;
  logic [8:0]         x0, y0, x1, y1;
  logic               y_last, x_last, clr_last, in_disc;

  // query neighbourhood
  logic [7:0]         qc_x, qc_y;
  logic               own_in;
  logic signed [9:0]  nb_x, nb_y;
  logic               nb_in, nb_last, toward, nb_pass;
  logic [27:0]        sum_sq;

  assign cfg_ready = 1'b1;

  // columns and rows beyond the grid saturate
  assign eff_w = (map_width  > 9'(GRID_COLS)) ? 9'(GRID_COLS) : map_width;
  assign eff_h = (map_height > 9'(GRID_ROWS)) ? 9'(GRID_ROWS) : map_height;

  assign mul_prod = mul_in * mul_in;
  assign mul_out  = mul_prod[26:0];
  assign sum_sq   = {1'b0, tmp} + {1'b0, mul_out};

  assign lo_x = $signed({2'b00, cen_x}) - $signed({5'b00000, rad});
  assign lo_y = $signed({2'b00, cen_y}) - $signed({5'b00000, rad});
  assign hi_x = {1'b0, cen_x} + {4'b0000, rad};
  assign hi_y = {1'b0, cen_y} + {4'b0000, rad};
  assign x0   = lo_x[13] ? 9'd0 : {1'b0, lo_x[11:4]};
  assign y0   = lo_y[13] ? 9'd0 : {1'b0, lo_y[11:4]};
  assign x1   = (hi_x[12:4] > eff_w) ? eff_w : hi_x[12:4];
  assign y1   = (hi_y[12:4] > eff_h) ? eff_h : hi_y[12:4];

  assign y_last   = (y_cnt + 9'd1) >= y1;
  assign x_last   = (x_cnt + 9'd1) >= x1;
  assign clr_last = (x_cnt == eff_w - 9'd1) && (y_cnt == eff_h - 9'd1);
  assign in_disc  = {10'd0, r2} >= sum_sq;

  assign qc_x   = qp_x[11:4];
  assign qc_y   = qp_y[11:4];
  assign own_in = ({1'b0, qc_x} < eff_w) && ({1'b0, qc_y} < eff_h);
  assign nb_x   = $signed({2'b00, qc_x}) + $signed({8'd0, nx}) - 10'sd1;
  assign nb_y   = $signed({2'b00, qc_y}) + $signed({8'd0, ny}) - 10'sd1;
  assign nb_in  = !nb_x[9] && (nb_x[8:0] < eff_w) && !nb_y[9] && (nb_y[8:0] < eff_h);
  assign nb_last = (nx == 2'd2) && (ny == 2'd2);
  assign toward  = (op_reg == OP_TOWARD);
  // strictly lower score, and strictly closer to the target when directed
  assign nb_pass = ({1'b0, rdata} < best) && (!toward || (sum_sq < own_d));

  // configuration writes, taken in any state
  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= MAP_SIZE_RESET;
      map_height <= MAP_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width  <= cfg_data;
        CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_INIT: begin
        if (init_cnt == AW'(DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (opcode_t'(opcode))
            OP_CLEAR:  state_next = (eff_w != 9'd0 && eff_h != 9'd0) ? ST_CLEAR : ST_DONE;
            OP_STAMP:  state_next = ST_STAMP_R2;
            OP_QUERY,
            OP_TOWARD: state_next = ST_Q_OWN_RD;
          endcase
        end
      end
      ST_CLEAR: begin
        if (clr_last) state_next = ST_DONE;
      end
      ST_STAMP_R2: begin
        state_next = (x0 >= x1 || y0 >= y1) ? ST_DONE : ST_STAMP_COL;
      end
      ST_STAMP_COL: state_next = ST_STAMP_CELL;
      ST_STAMP_CELL: begin
        if (y_last) state_next = x_last ? ST_DONE : ST_STAMP_COL;
      end
      ST_Q_OWN_RD: state_next = ST_Q_OWN;
      ST_Q_OWN:    state_next = ST_Q_NB_RD;
      ST_Q_NB_RD: begin
        if (nb_in)        state_next = ST_Q_NB_CHK;
        else if (nb_last) state_next = ST_DONE;
      end
      ST_Q_NB_CHK: state_next = nb_last ? ST_DONE : ST_Q_NB_RD;
      ST_DONE: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // sequencer outputs: handshake, memory port and squaring operand
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = '0;
    mem_wdata = '0;
    mul_in    = '0;
    unique case (state)
      ST_INIT: begin
        mem_we   = 1'b1;
        mem_addr = init_cnt;
      end
      ST_IDLE: in_ready = 1'b1;
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = AW'(int'(x_cnt[7:0]) * GRID_ROWS + int'(y_cnt[7:0]));
      end
      ST_STAMP_R2: mul_in = $signed({5'b00000, rad});
      ST_STAMP_COL: begin
        mul_in = $signed({2'b00, cen_x}) - $signed({2'b00, x_cnt[7:0], 4'b0000});
      end
      ST_STAMP_CELL: begin
        mul_in    = $signed({2'b00, cen_y}) - $signed({2'b00, y_cnt[7:0], 4'b0000});
        mem_we    = in_disc;
        mem_wdata = sc_val;
        mem_addr  = AW'(int'(x_cnt[7:0]) * GRID_ROWS + int'(y_cnt[7:0]));
      end
      ST_Q_OWN_RD: begin
        mul_in   = $signed({2'b00, qp_x}) - $signed({2'b00, tg_x});
        mem_re   = own_in;
        mem_addr = AW'(int'(qc_x) * GRID_ROWS + int'(qc_y));
      end
      ST_Q_OWN: mul_in = $signed({2'b00, qp_y}) - $signed({2'b00, tg_y});
      ST_Q_NB_RD: begin
        mul_in   = $signed({2'b00, nb_x[7:0], 4'b0000}) - $signed({2'b00, tg_x});
        mem_re   = nb_in;
        mem_addr = AW'(int'(nb_x[7:0]) * GRID_ROWS + int'(nb_y[7:0]));
      end
      ST_Q_NB_CHK: begin
        mul_in = $signed({2'b00, nb_y[7:0], 4'b0000}) - $signed({2'b00, tg_y});
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      init_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_INIT) init_cnt <= init_cnt + AW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          op_reg <= opcode_t'(opcode);
          cen_x  <= center_x;
          cen_y  <= center_y;
          rad    <= radius;
          sc_val <= score;
          qp_x   <= pos_x;
          qp_y   <= pos_y;
          tg_x   <= target_x;
          tg_y   <= target_y;
          x_cnt  <= 9'd0;
          y_cnt  <= 9'd0;
          bx     <= 8'd0;
          by     <= 8'd0;
        end
      end
      ST_CLEAR: begin
        if (y_cnt == eff_h - 9'd1) begin
          y_cnt <= 9'd0;
          x_cnt <= x_cnt + 9'd1;
        end else begin
          y_cnt <= y_cnt + 9'd1;
        end
      end
      ST_STAMP_R2: begin
        r2    <= mul_out[17:0];
        x_cnt <= x0;
        y_cnt <= y0;
      end
      ST_STAMP_COL: tmp <= mul_out;
      ST_STAMP_CELL: begin
        if (y_last) begin
          y_cnt <= y0;
          x_cnt <= x_cnt + 9'd1;
        end else begin
          y_cnt <= y_cnt + 9'd1;
        end
      end
      ST_Q_OWN_RD: tmp <= mul_out;
      ST_Q_OWN: begin
        own_d <= sum_sq;
        // own cell outside the map starts above every score
        best  <= own_in ? {1'b0, rdata} : BEST_NONE;
        bx    <= qc_x;
        by    <= qc_y;
        nx    <= 2'd0;
        ny    <= 2'd0;
      end
      ST_Q_NB_RD: begin
        if (nb_in) begin
          tmp <= mul_out;
        end else if (ny == 2'd2) begin
          ny <= 2'd0;
          nx <= nx + 2'd1;
        end else begin
          ny <= ny + 2'd1;
        end
      end
      ST_Q_NB_CHK: begin
        if (nb_pass) begin
          best <= {1'b0, rdata};
          bx   <= nb_x[7:0];
          by   <= nb_y[7:0];
        end
        if (ny == 2'd2) begin
          ny <= 2'd0;
          nx <= nx + 2'd1;
        end else begin
          ny <= ny + 2'd1;
        end
      end
      default: ;
    endcase
  end

  // score memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    if (mem_re) rdata <= mem[mem_addr];
  end

  // output register, parts the result from the item side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || out_ready)) begin
      waypoint_x  <= bx;
      waypoint_y  <= by;
      done_opcode <= op_reg;
    end
  end

endmodule

// ===== hdl/gdsnm_checker.sv =====
// gdsnm_props: port-level assertions for the influence grid top level
// depends on gdsnm_pkg; bound to grid_disc_stamp_and_neighbour_min_top below
module gdsnm_props (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] waypoint_x,
  input logic [7:0] waypoint_y,
  input logic [1:0] done_opcode
);
  import gdsnm_pkg::*;

  // clearing pass holds off items and results right after reset
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !in_ready && !out_valid)
    else $error("item or result seen during clearing pass");

  // one item at a time: busy after every item transfer
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after an item transfer");

  // clear and stamp results carry a zero waypoint
  a_zero_waypoint: assert property (@(posedge clk) disable iff (rst)
    out_valid && (done_opcode == OP_CLEAR || done_opcode == OP_STAMP)
      |-> waypoint_x == 8'd0 && waypoint_y == 8'd0)
    else $error("nonzero waypoint on clear or stamp result");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(waypoint_x)
      && $stable(waypoint_y) && $stable(done_opcode))
    else $error("stalled result changed");

endmodule

bind grid_disc_stamp_and_neighbour_min_top gdsnm_props u_gdsnm_props (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .waypoint_x  (waypoint_x),
  .waypoint_y  (waypoint_y),
  .done_opcode (done_opcode)
);

// ===== dv/gdsnm_checker.sv =====
`timescale 1ns / 1ps
// gdsnm_checker: watches the item, result and register channels of the influence grid,
// keeps its own copy of the score grid and compares every result; depends on gdsnm_pkg
module gdsnm_checker #(
  parameter int GRID_COLS = 256,
  parameter int GRID_ROWS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [11:0] center_x,
  input  logic [11:0] center_y,
  input  logic [8:0]  radius,
  input  logic [15:0] score,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [11:0] target_x,
  input  logic [11:0] target_y,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  waypoint_x,
  input  logic [7:0]  waypoint_y,
  input  logic [1:0]  done_opcode,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fail_count,
  output int          pending
);
  import gdsnm_pkg::*;

  typedef struct packed {
    logic [7:0] wx;
    logic [7:0] wy;
    logic [1:0] op;
  } waypoint_t;

  logic [15:0] score_copy [GRID_COLS*GRID_ROWS];
  int          map_w;
  int          map_h;
  int          errors;
  waypoint_t   waypoints_due [$];

  function automatic longint dist_sq(longint ax, longint ay, longint bx, longint by);
    return (ax - bx) * (ax - bx) + (ay - by) * (ay - by);
  endfunction

  // applies one item to the grid copy and returns the waypoint it yields
  function automatic waypoint_t next_waypoint(logic [1:0] op, int cx, int cy, int r,
                                              logic [15:0] sc, int px, int py,
                                              int tx, int ty);
    int        w, h, x0, x1, y0, y1, qx, qy, bx, by;
    logic [16:0] best;
    longint    own;
    waypoint_t res;
    w = (map_w > GRID_COLS) ? GRID_COLS : map_w;
    h = (map_h > GRID_ROWS) ? GRID_ROWS : map_h;
    res = '0;
    res.op = op;
    case (op)
      OP_CLEAR: begin
        for (int x = 0; x < w; x++)
          for (int y = 0; y < h; y++)
            score_copy[x*GRID_ROWS+y] = '0;
      end
      OP_STAMP: begin
        // box clamped at zero below, upper end exclusive and clamped to the map
        x0 = (cx - r < 0) ? 0 : (cx - r) / 16;
        y0 = (cy - r < 0) ? 0 : (cy - r) / 16;
        x1 = (cx + r) / 16;
        y1 = (cy + r) / 16;
        if (x1 > w) x1 = w;
        if (y1 > h) y1 = h;
        for (int x = x0; x < x1; x++)
          for (int y = y0; y < y1; y++)
            if (dist_sq(cx, cy, 16 * x, 16 * y) <= longint'(r) * r)
              score_copy[x*GRID_ROWS+y] = sc;
      end
      default: begin
        qx = px / 16;
        qy = py / 16;
        bx = qx;
        by = qy;
        best = BEST_NONE;
        own = dist_sq(px, py, tx, ty);
        if (qx < w && qy < h) best = {1'b0, score_copy[qx*GRID_ROWS+qy]};
        for (int x = qx - 1; x <= qx + 1; x++) begin
          if (x < 0 || x >= w) continue;
          for (int y = qy - 1; y <= qy + 1; y++) begin
            if (y < 0 || y >= h) continue;
            if ({1'b0, score_copy[x*GRID_ROWS+y]} >= best) continue;
            if (op == OP_TOWARD && !(dist_sq(16 * x, 16 * y, tx, ty) < own)) continue;
            best = {1'b0, score_copy[x*GRID_ROWS+y]};
            bx = x;
            by = y;
          end
        end
        res.wx = bx[7:0];
        res.wy = by[7:0];
      end
    endcase
    return res;
  endfunction

  always @(posedge clk) begin : watch
    waypoint_t got;
    waypoint_t want;
    if (rst) begin
      map_w = MAP_SIZE_RESET;
      map_h = MAP_SIZE_RESET;
      foreach (score_copy[i]) score_copy[i] = '0;
      waypoints_due.delete();
      errors = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{wx: waypoint_x, wy: waypoint_y, op: done_opcode};
        if (waypoints_due.size() == 0) begin
          $display("%0t: result (%0d,%0d) opcode %0d with nothing expected",
                   $time, got.wx, got.wy, got.op);
          errors++;
        end else begin
          want = waypoints_due.pop_front();
          if (got.wx !== want.wx) begin
            $display("%0t: waypoint_x expected %0d actual %0d", $time, want.wx, got.wx);
            errors++;
          end
          if (got.wy !== want.wy) begin
            $display("%0t: waypoint_y expected %0d actual %0d", $time, want.wy, got.wy);
            errors++;
          end
          if (got.op !== want.op) begin
            $display("%0t: done_opcode expected %0d actual %0d", $time, want.op, got.op);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MAP_WIDTH) map_w = cfg_data;
        else if (cfg_index == CFG_MAP_HEIGHT) map_h = cfg_data;
      end
      if (in_valid && in_ready)
        waypoints_due.push_back(next_waypoint(opcode, center_x, center_y, radius, score,
                                              pos_x, pos_y, target_x, target_y));
    end
    fail_count <= errors;
    pending <= waypoints_due.size();
  end

endmodule

// ===== dv/grid_disc_stamp_and_neighbour_min_top_tb.sv =====
`timescale 1ns / 1ps
// testbench top for the influence grid: makes items, register writes and result
// back-pressure, gives the verdict; depends on gdsnm_pkg, gdsnm_checker and the block
module grid_disc_stamp_and_neighbour_min_top_tb;
  import gdsnm_pkg::*;

  localparam int GRID_COLS       = 256;
  localparam int GRID_ROWS       = 256;
  localparam int RAND_PHASES     = 11;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int HOLD_CYCLES     = 300;
  // random clears only where the map is small enough to wipe quickly
  localparam int CLEAR_AREA_MAX  = 4096;

  typedef struct {
    logic [1:0]  op;
    logic [11:0] cx;
    logic [11:0] cy;
    logic [8:0]  r;
    logic [15:0] sc;
    logic [11:0] px;
    logic [11:0] py;
    logic [11:0] tx;
    logic [11:0] ty;
  } grid_item_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  opcode;
  logic [11:0] center_x;
  logic [11:0] center_y;
  logic [8:0]  radius;
  logic [15:0] score;
  logic [11:0] pos_x;
  logic [11:0] pos_y;
  logic [11:0] target_x;
  logic [11:0] target_y;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  waypoint_x;
  logic [7:0]  waypoint_y;
  logic [1:0]  done_opcode;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [8:0]  cfg_data;
  int          fail_count;
  int          pending;

  // map size the stimulus currently shapes its coordinates for
  int map_w = MAP_SIZE_RESET;
  int map_h = MAP_SIZE_RESET;
  // calm: no idle cycles on either side; hold_ask: bumped to request a long sink stall
  bit calm = 1'b0;
  int hold_ask = 0;

  // random phase map sizes: extremes, zero size, saturation above the grid, odd shapes
  int phase_w [RAND_PHASES] = '{8, 256, 1, 13, 0, 300, 32, 511, 64, 5, 17};
  int phase_h [RAND_PHASES] = '{8, 256, 40, 200, 9, 5, 32, 511, 3, 1, 23};

  always #5 clk = ~clk;

  grid_disc_stamp_and_neighbour_min_top #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) dut (.*);

  gdsnm_checker #(
    .GRID_COLS(GRID_COLS),
    .GRID_ROWS(GRID_ROWS)
  ) u_check (.*);

  // safety net: far beyond the slowest legal run including the clearing pass
  initial begin
    #30_000_000;
    $display("grid_disc_stamp_and_neighbour_min_top regression: fail");
    $finish;
  end

  // result sink: random stalls, one long hold-off on request, counted here
  initial begin : result_sink
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask != hold_seen) begin
        hold_seen = hold_ask;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 7);
      end
    end
  end

  // entered and left at a falling edge; valid stays up after the transfer so that
  // a following item can go out back to back
  task automatic send_item(input grid_item_t it);
    int gap;
    if (!calm && $urandom_range(99) < 7) begin
      gap = $urandom_range(8, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    opcode   <= it.op;
    center_x <= it.cx;
    center_y <= it.cy;
    radius   <= it.r;
    score    <= it.sc;
    pos_x    <= it.px;
    pos_y    <= it.py;
    target_x <= it.tx;
    target_y <= it.ty;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // drop valid and wait until every transfer in flight has come back
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // every item yields a result, so a drained queue means the block is idle
  task automatic set_map(input int w, input int h);
    wait_drain();
    write_reg(CFG_MAP_WIDTH, 9'(w));
    write_reg(CFG_MAP_HEIGHT, 9'(h));
    map_w = w;
    map_h = h;
  endtask

  function automatic grid_item_t mk(logic [1:0] op, int x, int y, int r, int sc,
                                    int tx, int ty);
    grid_item_t it;
    it.op = op;
    it.cx = 12'(x);
    it.cy = 12'(y);
    it.px = 12'(x);
    it.py = 12'(y);
    it.r  = 9'(r);
    it.sc = 16'(sc);
    it.tx = 12'(tx);
    it.ty = 12'(ty);
    return it;
  endfunction

  // mostly inside the map (plus one cell past its edge), sometimes anywhere
  function automatic logic [11:0] pick_coord(int cells);
    int hi;
    hi = (cells + 1) * 16 - 1;
    if (hi > 4095) hi = 4095;
    if ($urandom_range(99) < 85) return 12'($urandom_range(hi, 0));
    return 12'($urandom_range(4095, 0));
  endfunction

  function automatic grid_item_t random_item();
    grid_item_t it;
    int roll;
    int ew;
    int eh;
    ew = (map_w > GRID_COLS) ? GRID_COLS : map_w;
    eh = (map_h > GRID_ROWS) ? GRID_ROWS : map_h;
    roll = $urandom_range(99);
    if (roll < 4)       it.op = (ew * eh <= CLEAR_AREA_MAX) ? OP_CLEAR : OP_STAMP;
    else if (roll < 42) it.op = OP_STAMP;
    else if (roll < 72) it.op = OP_QUERY;
    else                it.op = OP_TOWARD;
    it.cx = pick_coord(ew);
    it.cy = pick_coord(eh);
    it.px = pick_coord(ew);
    it.py = pick_coord(eh);
    it.tx = pick_coord(ew);
    it.ty = pick_coord(eh);
    // small radii keep stamps cheap; the full range shows up now and then
    it.r = ($urandom_range(99) < 80) ? 9'($urandom_range(64, 0)) : 9'($urandom_range(511, 0));
    // narrow scores make ties, which exercise the strictly-lower test
    it.sc = $urandom_range(1) ? 16'($urandom_range(15, 0)) : 16'($urandom_range(65535, 0));
    return it;
  endfunction

  initial begin : stimulus
    grid_item_t directed [$];

    rst       = 1'b1;
    in_valid  = 1'b0;
    opcode    = OP_CLEAR;
    center_x  = '0;
    center_y  = '0;
    radius    = '0;
    score     = '0;
    pos_x     = '0;
    pos_y     = '0;
    target_x  = '0;
    target_y  = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_MAP_WIDTH;
    cfg_data  = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed, at the reset map size; the block runs its clearing pass first
    directed.push_back(mk(OP_QUERY, 0, 0, 0, 0, 0, 0));                 // empty grid, own cell
    directed.push_back(mk(OP_STAMP, 0, 0, 511, 65535, 0, 0));           // box clamped at zero
    directed.push_back(mk(OP_STAMP, 4095, 4095, 511, 1, 0, 0));         // box clamped at the edge
    directed.push_back(mk(OP_STAMP, 160, 160, 0, 7, 0, 0));             // zero radius, empty box
    directed.push_back(mk(OP_STAMP, 164, 164, 16, 0, 0, 0));
    directed.push_back(mk(OP_STAMP, 320, 320, 64, 100, 0, 0));
    directed.push_back(mk(OP_STAMP, 336, 336, 32, 50, 0, 0));           // later stamp overwrites
    directed.push_back(mk(OP_QUERY, 328, 328, 0, 0, 0, 0));
    directed.push_back(mk(OP_TOWARD, 328, 328, 0, 0, 4095, 0));
    directed.push_back(mk(OP_TOWARD, 328, 328, 0, 0, 328, 328));        // nothing closer
    directed.push_back(mk(OP_QUERY, 170, 170, 0, 0, 0, 0));
    directed.push_back(mk(OP_QUERY, 4095, 4095, 0, 0, 0, 0));           // corner, border skips
    directed.push_back(mk(OP_TOWARD, 4095, 4095, 0, 0, 0, 0));
    directed.push_back(mk(OP_QUERY, 0, 4095, 0, 0, 0, 0));
    directed.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));                 // full map clear
    directed.push_back(mk(OP_QUERY, 336, 336, 0, 0, 0, 0));
    directed.push_back(mk(OP_STAMP, 2048, 2048, 300, 65535, 0, 0));
    directed.push_back(mk(OP_TOWARD, 2056, 2056, 0, 0, 4095, 4095));
    foreach (directed[i]) send_item(directed[i]);

    // empty map: stamps write nothing, queries return their own cell
    set_map(0, 0);
    send_item(mk(OP_STAMP, 64, 64, 100, 9, 0, 0));
    send_item(mk(OP_QUERY, 64, 64, 0, 0, 0, 0));
    send_item(mk(OP_TOWARD, 64, 64, 0, 0, 0, 0));
    send_item(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0));

    // sizes above the grid saturate
    set_map(511, 511);
    send_item(mk(OP_STAMP, 4090, 4090, 40, 3, 0, 0));
    send_item(mk(OP_QUERY, 4095, 4080, 0, 0, 0, 0));

    // one-cell map: a position outside takes the first in-map neighbour
    set_map(1, 1);
    send_item(mk(OP_QUERY, 16, 16, 0, 0, 0, 0));
    send_item(mk(OP_TOWARD, 16, 16, 0, 0, 0, 0));
    send_item(mk(OP_QUERY, 40, 40, 0, 0, 0, 0));

    // random phases, one map size each
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_map(phase_w[p], phase_h[p]);
      calm = (p == 6);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // long sink stall while items keep coming, so the block backs up
        if (p == 0 && i == 10) hold_ask++;
        send_item(random_item());
      end
    end
    calm = 1'b0;

    wait_drain();
    repeat (50) @(negedge clk);
    if (fail_count == 0) $display("grid_disc_stamp_and_neighbour_min_top regression: pass");
    else $display("grid_disc_stamp_and_neighbour_min_top regression: fail");
    $finish;
  end

endmodule
